FILE: hw/rtl/heightmap_normal_map_builder_core_assert.svh
// ============================================================================
// Assertion macros for the heightmap normal map builder
// Concurrent check wrappers on clk and rst_n; empty bodies under SYNTHESIS.
// ============================================================================
`ifndef HEIGHTMAP_NORMAL_MAP_BUILDER_CORE_ASSERT_SVH
`define HEIGHTMAP_NORMAL_MAP_BUILDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HNMB_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hnmb implication check failed");
// next-cycle implication
`define HNMB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hnmb next-cycle check failed");
`else
`define HNMB_ASSERT_IMPLY(lbl, ante, cons)
`define HNMB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/hnmb_pkg.sv
// ============================================================================
// hnmb_pkg
// Shared types and constants of the heightmap normal map builder.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hnmb_pkg;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SELECT,
        ST_SLOPE_X,
        ST_SLOPE_Z,
        ST_SQUARE_X,
        ST_SQUARE_Z,
        ST_ROOT,
        ST_DIV_INIT,
        ST_DIVIDE,
        ST_LOAD,
        ST_FINISH
    } state_t;

    // which stencil result is being built, in raster output order
    typedef enum logic [1:0] {
        EMIT_INTERIOR,
        EMIT_RIGHT_EDGE,
        EMIT_BOTTOM_EDGE,
        EMIT_CORNER
    } emit_t;

    // controller to datapath
    typedef struct packed {
        logic  accept;
        emit_t sel;
        logic  last;
        logic  slope_x;
        logic  slope_z;
        logic  square_x;
        logic  square_z;
        logic  root_step;
        logic  div_init;
        logic  div_step;
        logic  out_load;
        logic  finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [3:0] emit_mask;
        logic       out_free;
    } status_t;

    // iteration counts
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 8;
    localparam int STEP_CNT_W = 5;

    // arithmetic widths
    localparam int SLOPE_W = 32;
    localparam int SQ_W    = 64;
    localparam int LEN_W   = 32;
    localparam int T_W     = 34;
    localparam int NUM_W   = 42;
    localparam int DSH_W   = 40;

    localparam logic [SQ_W-1:0]  ROOT_FIRST_BIT = 64'h4000_0000_0000_0000;
    localparam logic [SQ_W-1:0]  UNIT_SQUARE    = 64'h0000_0001_0000_0000;
    localparam logic [T_W-1:0]   GREEN_N        = 34'd65536;
    localparam logic [7:0]       ALPHA_VALUE    = 8'hFF;

    // register map
    localparam int         APB_ADDR_W = 4;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INV_SPACING  = 2'd2;

    localparam logic [12:0] RESET_IMAGE_WIDTH  = 13'd256;
    localparam logic [15:0] RESET_IMAGE_HEIGHT = 16'd256;
    localparam logic [15:0] RESET_INV_SPACING  = 16'd128;

endpackage

`default_nettype wire

FILE: hw/rtl/hnmb_ctrl.sv
// ============================================================================
// hnmb_ctrl
// Sequencer: walks the pending results of one height sample through slope,
// square, root, divide and output load, then retires the sample.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hnmb_ctrl
    import hnmb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    height_valid,
    output logic         height_stall,
    input  status_t      status,
    output cmd_t         cmd
);

    state_t                 state_reg, state_next;
    logic [3:0]             mask_reg, mask_next;
    emit_t                  sel_reg, sel_next;
    logic                   last_reg, last_next;
    logic [STEP_CNT_W-1:0]  cnt_reg, cnt_next;

    // state and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mask_reg  <= '0;
            sel_reg   <= EMIT_INTERIOR;
            last_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            sel_reg   <= sel_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        mask_next  = mask_reg;
        sel_next   = sel_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.last   = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (height_valid)
                begin
                    cmd.accept = 1'b1;
                    mask_next  = status.emit_mask;
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                // lowest pending result goes first
                priority if (mask_reg[0])
                begin
                    sel_next  = EMIT_INTERIOR;
                    mask_next = mask_reg & 4'b1110;
                end
                else if (mask_reg[1])
                begin
                    sel_next  = EMIT_RIGHT_EDGE;
                    mask_next = mask_reg & 4'b1100;
                end
                else if (mask_reg[2])
                begin
                    sel_next  = EMIT_BOTTOM_EDGE;
                    mask_next = mask_reg & 4'b1000;
                end
                else if (mask_reg[3])
                begin
                    sel_next  = EMIT_CORNER;
                    mask_next = 4'b0000;
                end
                else
                begin
                    mask_next = mask_reg;
                end
                last_next  = (mask_next == 4'b0000);
                state_next = (mask_reg == 4'b0000) ? ST_FINISH : ST_SLOPE_X;
            end
            ST_SLOPE_X:
            begin
                cmd.slope_x = 1'b1;
                state_next  = ST_SLOPE_Z;
            end
            ST_SLOPE_Z:
            begin
                cmd.slope_z = 1'b1;
                state_next  = ST_SQUARE_X;
            end
            ST_SQUARE_X:
            begin
                cmd.square_x = 1'b1;
                state_next   = ST_SQUARE_Z;
            end
            ST_SQUARE_Z:
            begin
                cmd.square_z = 1'b1;
                cnt_next     = '0;
                state_next   = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_SELECT;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign height_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/hnmb_datapath.sv
// ============================================================================
// hnmb_datapath
// Line stores, stencil registers, slope multiplier, squarer, bit-serial
// square root, three restoring dividers and the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hnmb_datapath
    import hnmb_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int HEIGHT_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [HEIGHT_BITS-1:0] height_sample,
    input  wire logic [12:0]            cfg_width,
    input  wire logic [15:0]            cfg_height,
    input  wire logic [15:0]            cfg_spacing,
    input  cmd_t                        cmd,
    output status_t                     status,
    input  wire logic                   normal_stall,
    output logic                        normal_valid,
    output logic [11:0]                 texel_column,
    output logic [15:0]                 texel_row,
    output logic [7:0]                  red_channel,
    output logic [7:0]                  green_channel,
    output logic [7:0]                  blue_channel,
    output logic [7:0]                  alpha_channel,
    output logic                        last_of_run,
    output logic                        end_of_frame
);

    localparam int HB   = HEIGHT_BITS;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CNTW = CW + 1;
    localparam int PW   = HB + 18;

    // line stores
    logic [HB-1:0] center_mem [MAX_WIDTH];
    logic [HB-1:0] upper_mem  [MAX_WIDTH];
    logic [HB-1:0] a_rd_reg, b_rd_reg;

    // stencil and position state
    logic [HB-1:0] s_reg;
    logic [HB-1:0] prev_reg, prev2_reg, mid1_reg, mid2_reg, up1_reg;
    logic [CW-1:0] col_cnt_reg;
    logic [15:0]   row_cnt_reg;

    // arithmetic state
    logic signed [SLOPE_W-1:0] dx_reg, dz_reg;
    logic [SQ_W-1:0]           sq_reg, v_reg, root_reg, bit_reg;
    logic [DSH_W-1:0]          dsh_reg;
    logic [NUM_W-1:0]          rem_r_reg, rem_g_reg, rem_b_reg;
    logic [7:0]                q_r_reg, q_g_reg, q_b_reg;

    // output register
    logic        out_valid_reg;
    logic [11:0] out_col_reg;
    logic [15:0] out_row_reg;
    logic [7:0]  out_r_reg, out_g_reg, out_b_reg;
    logic        out_last_reg, out_eof_reg;

    // frame geometry
    logic [CNTW-1:0] w_eff;
    logic [15:0]     h_eff;
    logic            last_col, last_row, col_zero, row_zero;

    always_comb
    begin
        if (cfg_width == 13'd0)
        begin
            w_eff = CNTW'(1);
        end
        else if (32'(cfg_width) > MAX_WIDTH)
        begin
            w_eff = CNTW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CNTW'(cfg_width);
        end
    end

    assign h_eff    = (cfg_height == 16'd0) ? 16'd1 : cfg_height;
    assign last_col = (CNTW'(col_cnt_reg) + CNTW'(1)) >= w_eff;
    assign last_row = ({1'b0, row_cnt_reg} + 17'd1) >= {1'b0, h_eff};
    assign col_zero = (col_cnt_reg == '0);
    assign row_zero = (row_cnt_reg == 16'd0);

    // pending results, bit order follows emit_t
    assign status.emit_mask = {last_row & last_col,
                               last_row & ~col_zero,
                               ~row_zero & last_col,
                               ~row_zero & ~col_zero};
    assign status.out_free  = ~out_valid_reg | ~normal_stall;

    // store reads every cycle at the current column
    always_ff @(posedge clk)
    begin
        a_rd_reg <= center_mem[col_cnt_reg];
        b_rd_reg <= upper_mem[col_cnt_reg];
        if (cmd.finish)
        begin
            upper_mem[col_cnt_reg]  <= a_rd_reg;
            center_mem[col_cnt_reg] <= s_reg;
        end
    end

    // sample capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            s_reg <= height_sample;
        end
    end

    // delay registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            prev2_reg   <= '0;
            mid1_reg    <= '0;
            mid2_reg    <= '0;
            up1_reg     <= '0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cmd.finish)
        begin
            mid2_reg  <= mid1_reg;
            mid1_reg  <= a_rd_reg;
            up1_reg   <= b_rd_reg;
            prev2_reg <= prev_reg;
            prev_reg  <= s_reg;
            if (last_col)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row ? 16'd0 : row_cnt_reg + 16'd1;
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + CW'(1);
            end
        end
    end

    // stencil operands of the selected result
    logic [CW-1:0] col_sel;
    logic [15:0]   row_sel;
    logic [HB-1:0] op_left, op_right, op_up, op_down;
    logic          col_is_one, row_is_one;

    assign col_is_one = (col_cnt_reg == CW'(1));
    assign row_is_one = (row_cnt_reg == 16'd1);

    always_comb
    begin
        unique case (cmd.sel)
            EMIT_INTERIOR:
            begin
                col_sel  = col_cnt_reg - CW'(1);
                row_sel  = row_cnt_reg - 16'd1;
                op_left  = col_is_one ? mid1_reg : mid2_reg;
                op_right = a_rd_reg;
                op_up    = row_is_one ? mid1_reg : up1_reg;
                op_down  = prev_reg;
            end
            EMIT_RIGHT_EDGE:
            begin
                col_sel  = col_cnt_reg;
                row_sel  = row_cnt_reg - 16'd1;
                op_left  = col_zero ? a_rd_reg : mid1_reg;
                op_right = a_rd_reg;
                op_up    = row_is_one ? a_rd_reg : b_rd_reg;
                op_down  = s_reg;
            end
            EMIT_BOTTOM_EDGE:
            begin
                col_sel  = col_cnt_reg - CW'(1);
                row_sel  = row_cnt_reg;
                op_left  = col_is_one ? prev_reg : prev2_reg;
                op_right = s_reg;
                op_up    = row_zero ? prev_reg : mid1_reg;
                op_down  = prev_reg;
            end
            EMIT_CORNER:
            begin
                col_sel  = col_cnt_reg;
                row_sel  = row_cnt_reg;
                op_left  = col_zero ? s_reg : prev_reg;
                op_right = s_reg;
                op_up    = row_zero ? s_reg : a_rd_reg;
                op_down  = s_reg;
            end
        endcase
    end

    // slope: difference times Q8.8 spacing, placed in Q16.16 and saturated
    logic [HB-1:0]             slope_lo, slope_hi;
    logic signed [HB:0]        slope_diff;
    logic signed [16:0]        spacing_s;
    logic signed [PW-1:0]      slope_prod;
    logic [PW-24:0]            slope_top;
    logic                      slope_ovf;
    logic signed [SLOPE_W-1:0] slope_sat;

    assign slope_lo   = cmd.slope_z ? op_up   : op_left;
    assign slope_hi   = cmd.slope_z ? op_down : op_right;
    assign slope_diff = $signed({slope_hi[HB-1], slope_hi})
                      - $signed({slope_lo[HB-1], slope_lo});
    assign spacing_s  = $signed({1'b0, cfg_spacing});
    assign slope_prod = slope_diff * spacing_s;
    assign slope_top  = slope_prod[PW-1:23];
    assign slope_ovf  = !((&slope_top) || !(|slope_top));
    assign slope_sat  = slope_ovf
                      ? (slope_prod[PW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                      : $signed({slope_prod[23:0], 8'h00});

    always_ff @(posedge clk)
    begin
        if (cmd.slope_x)
        begin
            dx_reg <= slope_sat;
        end
        if (cmd.slope_z)
        begin
            dz_reg <= slope_sat;
        end
    end

    // squared length, shared squarer
    logic signed [SLOPE_W-1:0] sq_in;
    logic signed [SQ_W-1:0]    sq_prod;

    assign sq_in   = cmd.square_z ? dz_reg : dx_reg;
    assign sq_prod = sq_in * sq_in;

    // bit-serial integer square root, two radicand bits per step
    logic [SQ_W-1:0] root_trial;
    assign root_trial = root_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.square_x)
        begin
            sq_reg <= $unsigned(sq_prod);
        end
        if (cmd.square_z)
        begin
            v_reg    <= sq_reg + $unsigned(sq_prod) + UNIT_SQUARE;
            root_reg <= '0;
            bit_reg  <= ROOT_FIRST_BIT;
        end
        else if (cmd.root_step)
        begin
            if (v_reg >= root_trial)
            begin
                v_reg    <= v_reg - root_trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // channel numerators 255*(L+n)+L, divided by 2L
    function automatic logic [NUM_W-1:0] enc_num(input logic [T_W-1:0] t,
                                                 input logic [LEN_W-1:0] len);
        enc_num = (NUM_W'(t) << 8) - NUM_W'(t) + NUM_W'(len);
    endfunction

    logic [LEN_W-1:0]      len;
    logic signed [T_W-1:0] n_red, n_blue, t_red, t_blue;
    logic [T_W-1:0]        t_green;

    assign len     = root_reg[LEN_W-1:0];
    assign n_red   = -$signed({{2{dx_reg[SLOPE_W-1]}}, dx_reg});
    assign n_blue  = -$signed({{2{dz_reg[SLOPE_W-1]}}, dz_reg});
    assign t_red   = $signed({2'b00, len}) + n_red;
    assign t_blue  = $signed({2'b00, len}) + n_blue;
    assign t_green = {2'b00, len} + GREEN_N;

    // three restoring dividers, one quotient bit per step
    logic [NUM_W-1:0] dsh_ext;
    assign dsh_ext = {2'b00, dsh_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_r_reg <= enc_num($unsigned(t_red), len);
            rem_g_reg <= enc_num(t_green, len);
            rem_b_reg <= enc_num($unsigned(t_blue), len);
            dsh_reg   <= {len, 8'h00};
        end
        else if (cmd.div_step)
        begin
            if (rem_r_reg >= dsh_ext)
            begin
                rem_r_reg <= rem_r_reg - dsh_ext;
                q_r_reg   <= {q_r_reg[6:0], 1'b1};
            end
            else
            begin
                q_r_reg <= {q_r_reg[6:0], 1'b0};
            end
            if (rem_g_reg >= dsh_ext)
            begin
                rem_g_reg <= rem_g_reg - dsh_ext;
                q_g_reg   <= {q_g_reg[6:0], 1'b1};
            end
            else
            begin
                q_g_reg <= {q_g_reg[6:0], 1'b0};
            end
            if (rem_b_reg >= dsh_ext)
            begin
                rem_b_reg <= rem_b_reg - dsh_ext;
                q_b_reg   <= {q_b_reg[6:0], 1'b1};
            end
            else
            begin
                q_b_reg <= {q_b_reg[6:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_col_reg  <= 12'(col_sel);
            out_row_reg  <= row_sel;
            out_r_reg    <= q_r_reg;
            out_g_reg    <= q_g_reg;
            out_b_reg    <= q_b_reg;
            out_last_reg <= cmd.last;
            out_eof_reg  <= (cmd.sel == EMIT_CORNER);
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!normal_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign normal_valid  = out_valid_reg;
    assign texel_column  = out_col_reg;
    assign texel_row     = out_row_reg;
    assign red_channel   = out_r_reg;
    assign green_channel = out_g_reg;
    assign blue_channel  = out_b_reg;
    assign alpha_channel = ALPHA_VALUE;
    assign last_of_run   = out_last_reg;
    assign end_of_frame  = out_eof_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/heightmap_normal_map_builder_core.sv
// Sequencing: a sample that yields k results (k = 0..4) holds the block for k passes through
//   slope, square, root, divide and output load, and a new sample is taken only when it is done.
// Each result runs the 32-step square root and the 8-step channel dividers; its output load
//   waits while the output register is held by normal_stall.
// Reset: rst_n clears counters, delay registers, config to defaults; line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_normal_map_builder_core_assert.svh"
// ============================================================================
// heightmap_normal_map_builder_core
// Streaming height field to RGBA normal map with APB configuration.
// ============================================================================

module heightmap_normal_map_builder_core
    import hnmb_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int HEIGHT_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // height samples
    input  wire logic                   height_valid,
    output logic                        height_stall,
    input  wire logic [HEIGHT_BITS-1:0] height_sample,
    // normals
    output logic                        normal_valid,
    input  wire logic                   normal_stall,
    output logic [11:0]                 texel_column,
    output logic [15:0]                 texel_row,
    output logic [7:0]                  red_channel,
    output logic [7:0]                  green_channel,
    output logic [7:0]                  blue_channel,
    output logic [7:0]                  alpha_channel,
    output logic                        last_of_run,
    output logic                        end_of_frame
);

    logic [12:0] cfg_width_reg;
    logic [15:0] cfg_height_reg;
    logic [15:0] cfg_spacing_reg;
    logic [1:0]  reg_index;
    logic        cfg_write;
    cmd_t        cmd;
    status_t     status;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg   <= RESET_IMAGE_WIDTH;
            cfg_height_reg  <= RESET_IMAGE_HEIGHT;
            cfg_spacing_reg <= RESET_INV_SPACING;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg   <= pwdata[12:0];
                REG_IMAGE_HEIGHT: cfg_height_reg  <= pwdata[15:0];
                REG_INV_SPACING:  cfg_spacing_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_index)
            REG_IMAGE_WIDTH:  prdata = {19'd0, cfg_width_reg};
            REG_IMAGE_HEIGHT: prdata = {16'd0, cfg_height_reg};
            REG_INV_SPACING:  prdata = {16'd0, cfg_spacing_reg};
            default:          prdata = 32'd0;
        endcase
    end

    hnmb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .height_valid (height_valid),
        .height_stall (height_stall),
        .status       (status),
        .cmd          (cmd)
    );

    hnmb_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .height_sample (height_sample),
        .cfg_width     (cfg_width_reg),
        .cfg_height    (cfg_height_reg),
        .cfg_spacing   (cfg_spacing_reg),
        .cmd           (cmd),
        .status        (status),
        .normal_stall  (normal_stall),
        .normal_valid  (normal_valid),
        .texel_column  (texel_column),
        .texel_row     (texel_row),
        .red_channel   (red_channel),
        .green_channel (green_channel),
        .blue_channel  (blue_channel),
        .alpha_channel (alpha_channel),
        .last_of_run   (last_of_run),
        .end_of_frame  (end_of_frame)
    );

    // checks
    `HNMB_ASSERT_NEXT(a_busy_after_take, height_valid && !height_stall, height_stall)
    `HNMB_ASSERT_IMPLY(a_eof_is_last, normal_valid && end_of_frame, last_of_run)
    `HNMB_ASSERT_IMPLY(a_load_when_free, cmd.out_load, status.out_free)

endmodule

`default_nettype wire
